FILE: design/fgs_pkg.sv
`default_nettype none
package fgs_pkg;

   // Sample width held in the scan stores.
   localparam int RangeBits = 16;

   // Configuration register indexes.
   localparam logic [1:0] CsrMaxRange     = 2'd0;
   localparam logic [1:0] CsrBubbleRadius = 2'd1;
   localparam logic [1:0] CsrStartAngle   = 2'd2;
   localparam logic [1:0] CsrAngleStep    = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [15:0]        MaxRangeReset     = 16'd3000;
   localparam logic [7:0]         BubbleRadiusReset = 8'd20;
   localparam logic signed [31:0] StartAngleReset   = -32'sd154403;
   localparam logic [15:0]        AngleStepReset    = 16'd286;

   // Reciprocal of three for a 20-bit shift; exact for sums below 2^19.
   localparam logic [19:0] RecipThree = 20'd349526;

   typedef struct packed {
      logic [15:0] range_sample;
      logic        sample_invalid;
      logic        last_sample;
   } fgs_req_type;

   typedef struct packed {
      logic signed [31:0] steer_angle;
      logic [9:0]         target_index;
      logic [10:0]        gap_first;
      logic [10:0]        gap_after;
   } fgs_rsp_type;

   typedef struct packed {
      logic [15:0]        max_range;
      logic [7:0]         bubble_reach;
      logic signed [31:0] start_angle;
      logic [15:0]        angle_step;
   } fgs_cfg_type;

   // One classified sample as it passes from the front to the back.
   typedef struct packed {
      logic [RangeBits-1:0] value;
      logic                 last;
   } fgs_word_type;

endpackage
`default_nettype wire

FILE: design/fgs_front.sv
`default_nettype none
module fgs_front
   import fgs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [15:0]  max_range,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire fgs_req_type  req_data,
   output logic              q_valid,
   input  wire logic         q_pop,
   output fgs_word_type      q_word
);

   fgs_word_type   slot_ff [2];
   logic           wptr_ff, wptr_in;
   logic           rptr_ff, rptr_in;
   logic [1:0]     fill_ff, fill_in;
   logic           push;
   logic           pop;
   fgs_word_type   word;

   // Clip the sample: invalid or over-limit readings become empty.
   always_comb begin
      word.last = req_data.last_sample;
      if (req_data.sample_invalid || (req_data.range_sample > max_range)) begin
         word.value = '0;
      end else begin
         word.value = req_data.range_sample[RangeBits-1:0];
      end
   end

   // Two-entry queue between the front and the back.
   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_word    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= word;
      end
   end

endmodule
`default_nettype wire

FILE: design/fgs_back.sv
`default_nettype none
module fgs_back
   import fgs_pkg::*;
#(
   parameter int SCAN_POINTS = 1024
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire fgs_cfg_type  cfg,
   input  wire logic         q_valid,
   output logic              q_pop,
   input  wire fgs_word_type q_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output fgs_rsp_type       rsp_data
);

   localparam int AW = $clog2(SCAN_POINTS);
   localparam int CW = $clog2(SCAN_POINTS + 1);
   localparam int PW = CW + 1;
   localparam int HW = CW + 8;
   localparam logic [CW-1:0] Depth = CW'(SCAN_POINTS);

   typedef enum logic [2:0] {
      LOAD, SMOOTH, NEAREST, BUB_SETUP, BUBBLE, GAP, TARGET, EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [PW-1:0]        pass_ff, pass_in;
   logic [RangeBits-1:0] wa_ff, wa_in, wb_ff, wb_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [17:0]          s1_sum_ff, s1_sum_in;
   logic [1:0]           s1_cnt_ff, s1_cnt_in;
   logic                 s1_zero_ff, s1_zero_in;
   logic [AW-1:0]        s1_idx_ff, s1_idx_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic [RangeBits-1:0] s2_q_ff, s2_q_in;
   logic [AW-1:0]        s2_idx_ff, s2_idx_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        near_idx_ff, near_idx_in;
   logic [RangeBits-1:0] near_val_ff, near_val_in;
   logic [AW-1:0]        bub_addr_ff, bub_addr_in;
   logic [AW-1:0]        bub_hi_ff, bub_hi_in;
   logic                 in_run_ff, in_run_in;
   logic [CW-1:0]        run_start_ff, run_start_in;
   logic [CW-1:0]        best_first_ff, best_first_in;
   logic [CW-1:0]        best_after_ff, best_after_in;
   logic [CW-1:0]        target_ff, target_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fgs_rsp_type          rsp_data_ff, rsp_data_in;

   logic [RangeBits-1:0] clip_mem [SCAN_POINTS];
   logic [RangeBits-1:0] sm_mem [SCAN_POINTS];
   logic [RangeBits-1:0] clip_rd_ff;
   logic [RangeBits-1:0] sm_rd_ff;
   logic                 clip_we;
   logic                 sm_we;
   logic [AW-1:0]        sm_waddr;
   logic [RangeBits-1:0] sm_wdata;
   logic [AW-1:0]        rd_addr;

   logic [PW-1:0]        n_ext;
   logic                 has_prev, has_next;
   logic [37:0]          third_prod;
   logic [CW-1:0]        k_idx;
   logic [CW-1:0]        seg_start;
   logic [CW-1:0]        seg_end;
   logic                 seg_close;
   logic [HW-1:0]        hi_sum;
   logic [CW:0]          bound_sum;
   logic [CW+15:0]       angle_prod;

   assign n_ext      = {1'b0, n_ff};
   assign rd_addr    = pass_ff[AW-1:0];
   assign q_pop      = (state_ff == LOAD);
   assign clip_we    = q_pop && q_valid && (count_ff < Depth);
   assign third_prod = {s1_sum_ff, 20'b0} >> 20 == 38'd0 ? 38'd0
                       : ({20'b0, s1_sum_ff} * {18'b0, RecipThree});
   assign k_idx      = CW'(pass_ff - PW'(1));
   assign bound_sum  = {1'b0, best_first_ff} + {1'b0, best_after_ff};
   assign angle_prod = (CW+16)'(target_ff) * (CW+16)'(cfg.angle_step);
   assign hi_sum     = HW'(near_idx_ff) + HW'(cfg.bubble_reach);

   // Window flags for the sample at the centre of the smoothing taps.
   assign has_prev = (pass_ff >= PW'(3));
   assign has_next = (pass_ff <= n_ext);

   // Run bookkeeping for the gap search.
   always_comb begin
      seg_close = 1'b0;
      seg_start = run_start_ff;
      seg_end   = k_idx;
      if (sm_rd_ff != '0) begin
         seg_start = in_run_ff ? run_start_ff : k_idx;
         seg_end   = n_ff;
         seg_close = (k_idx == n_ff - CW'(1));
      end else begin
         seg_close = in_run_ff;
      end
   end

   // Smoothed store write port: smoothing results or bubble clearing.
   always_comb begin
      if (state_ff == BUBBLE) begin
         sm_we    = 1'b1;
         sm_waddr = bub_addr_ff;
         sm_wdata = '0;
      end else begin
         sm_we    = (state_ff == SMOOTH) && s2_valid_ff;
         sm_waddr = s2_idx_ff;
         sm_wdata = s2_q_ff;
      end
   end

   // Next-state logic for the sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      pass_in       = pass_ff;
      wa_in         = wa_ff;
      wb_in         = wb_ff;
      s1_valid_in   = 1'b0;
      s1_sum_in     = s1_sum_ff;
      s1_cnt_in     = s1_cnt_ff;
      s1_zero_in    = s1_zero_ff;
      s1_idx_in     = s1_idx_ff;
      s2_valid_in   = s1_valid_ff;
      s2_idx_in     = s1_idx_ff;
      s2_q_in       = s2_q_ff;
      found_in      = found_ff;
      near_idx_in   = near_idx_ff;
      near_val_in   = near_val_ff;
      bub_addr_in   = bub_addr_ff;
      bub_hi_in     = bub_hi_ff;
      in_run_in     = in_run_ff;
      run_start_in  = run_start_ff;
      best_first_in = best_first_ff;
      best_after_in = best_after_ff;
      target_in     = target_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      // Divide the window sum by the number of samples in it; an empty centre sample stays empty.
      if (s1_zero_ff) begin
         s2_q_in = '0;
      end else if (s1_cnt_ff == 2'd3) begin
         s2_q_in = third_prod[35:20];
      end else if (s1_cnt_ff == 2'd2) begin
         s2_q_in = s1_sum_ff[16:1];
      end else begin
         s2_q_in = s1_sum_ff[15:0];
      end

      unique case (state_ff)
         LOAD: begin
            if (q_valid) begin
               if (count_ff < Depth) begin
                  count_in = count_ff + CW'(1);
               end
               if (q_word.last) begin
                  n_in          = (count_ff < Depth) ? count_ff + CW'(1) : count_ff;
                  count_in      = '0;
                  pass_in       = '0;
                  found_in      = 1'b0;
                  near_idx_in   = '0;
                  near_val_in   = '1;
                  in_run_in     = 1'b0;
                  run_start_in  = '0;
                  best_first_in = '0;
                  best_after_in = '0;
                  state_in      = SMOOTH;
               end
            end
         end
         SMOOTH: begin
            pass_in = pass_ff + PW'(1);
            if (pass_ff >= PW'(1)) begin
               wa_in = wb_ff;
               wb_in = clip_rd_ff;
            end
            if ((pass_ff >= PW'(2)) && (pass_ff <= n_ext + PW'(1))) begin
               s1_valid_in = 1'b1;
               s1_sum_in   = 18'(wb_ff) + (has_prev ? 18'(wa_ff) : 18'd0)
                             + (has_next ? 18'(clip_rd_ff) : 18'd0);
               s1_cnt_in   = 2'd1 + {1'b0, has_prev} + {1'b0, has_next};
               s1_zero_in  = (wb_ff == '0);
               s1_idx_in   = AW'(pass_ff - PW'(2));
            end
            if (pass_ff == n_ext + PW'(3)) begin
               pass_in  = '0;
               state_in = NEAREST;
            end
         end
         NEAREST: begin
            pass_in = pass_ff + PW'(1);
            if ((pass_ff >= PW'(1)) && (sm_rd_ff != '0)
                && (!found_ff || (sm_rd_ff < near_val_ff))) begin
               found_in    = 1'b1;
               near_val_in = sm_rd_ff;
               near_idx_in = AW'(k_idx);
            end
            if (pass_ff == n_ext) begin
               state_in = BUB_SETUP;
            end
         end
         BUB_SETUP: begin
            pass_in = '0;
            if (found_ff) begin
               bub_addr_in = (near_idx_ff >= AW'(cfg.bubble_reach))
                             && (AW >= 8 || near_idx_ff >= AW'(cfg.bubble_reach))
                             && (HW'(near_idx_ff) >= HW'(cfg.bubble_reach))
                             ? AW'(HW'(near_idx_ff) - HW'(cfg.bubble_reach)) : '0;
               bub_hi_in   = (hi_sum >= HW'(n_ff)) ? AW'(n_ff - CW'(1)) : AW'(hi_sum);
               state_in    = BUBBLE;
            end else begin
               state_in = GAP;
            end
         end
         BUBBLE: begin
            bub_addr_in = bub_addr_ff + AW'(1);
            if (bub_addr_ff == bub_hi_ff) begin
               pass_in  = '0;
               state_in = GAP;
            end
         end
         GAP: begin
            pass_in = pass_ff + PW'(1);
            if (pass_ff >= PW'(1)) begin
               if ((sm_rd_ff != '0) && !in_run_ff) begin
                  in_run_in    = 1'b1;
                  run_start_in = k_idx;
               end
               if (sm_rd_ff == '0) begin
                  in_run_in = 1'b0;
               end
               if (seg_close && ((seg_end - seg_start) > (best_after_ff - best_first_ff))) begin
                  best_first_in = seg_start;
                  best_after_in = seg_end;
               end
            end
            if (pass_ff == n_ext) begin
               state_in = TARGET;
            end
         end
         TARGET: begin
            target_in = bound_sum[CW:1];
            state_in  = EMIT;
         end
         EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.steer_angle     = cfg.start_angle + 32'(angle_prod);
               rsp_data_in.target_index    = 10'(target_ff);
               rsp_data_in.gap_first       = 11'(best_first_ff);
               rsp_data_in.gap_after       = 11'(best_after_ff);
               state_in                    = LOAD;
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         count_ff     <= '0;
         pass_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         near_idx_ff  <= '0;
         near_val_ff  <= '1;
         in_run_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pass_ff      <= pass_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         found_ff     <= found_in;
         near_idx_ff  <= near_idx_in;
         near_val_ff  <= near_val_in;
         in_run_ff    <= in_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      wa_ff         <= wa_in;
      wb_ff         <= wb_in;
      s1_sum_ff     <= s1_sum_in;
      s1_cnt_ff     <= s1_cnt_in;
      s1_zero_ff    <= s1_zero_in;
      s1_idx_ff     <= s1_idx_in;
      s2_q_ff       <= s2_q_in;
      s2_idx_ff     <= s2_idx_in;
      bub_addr_ff   <= bub_addr_in;
      bub_hi_ff     <= bub_hi_in;
      run_start_ff  <= run_start_in;
      best_first_ff <= best_first_in;
      best_after_ff <= best_after_in;
      target_ff     <= target_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Clipped store: written while loading, read during smoothing.
   always_ff @(posedge clock) begin
      if (clip_we) begin
         clip_mem[count_ff[AW-1:0]] <= q_word.value;
      end
      clip_rd_ff <= clip_mem[rd_addr];
   end

   // Smoothed store: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (sm_we) begin
         sm_mem[sm_waddr] <= sm_wdata;
      end
      sm_rd_ff <= sm_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: design/follow_the_gap_steering_top.sv
`default_nettype none
// Gap-following steering for one lidar scan. Samples are taken one a cycle
// through a two-word queue while it is not full; flagged or over-range
// samples are stored as empty. The word carrying last_sample starts the scan
// processing, during which the back takes no further samples from the queue:
// smoothing, the nearest-point search, the bubble, the gap search and the
// result run in turn, as passes sharing one read address into the two stores.
// The result then waits in an output register while the next scan loads.
module follow_the_gap_steering_top
   import fgs_pkg::*;
#(
   parameter int SCAN_POINTS = 1024
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire fgs_req_type  req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output fgs_rsp_type       rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   fgs_cfg_type  cfg_ff, cfg_in;
   logic         q_valid;
   logic         q_pop;
   fgs_word_type q_word;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrMaxRange:     cfg_in.max_range     = csr_data[15:0];
            CsrBubbleRadius: cfg_in.bubble_reach  = csr_data[7:0];
            CsrStartAngle:   cfg_in.start_angle   = csr_data;
            CsrAngleStep:    cfg_in.angle_step    = csr_data[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_range     <= MaxRangeReset;
         cfg_ff.bubble_reach  <= BubbleRadiusReset;
         cfg_ff.start_angle   <= StartAngleReset;
         cfg_ff.angle_step    <= AngleStepReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fgs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .max_range (cfg_ff.max_range),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_word    (q_word)
   );

   fgs_back #(
      .SCAN_POINTS (SCAN_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_word    (q_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
